// ----- sv/pirm_pkg.sv -----
package pirm_pkg;

	localparam int SAMPLE_BITS_DEF = 18;
	localparam int RAW_W = 24;
	localparam int TICK_W = 32;
	localparam int RATE_W = 12;
	localparam int STEP_W = 18;
	localparam int LIMIT_W = 8;
	localparam int QUOT_W = 20;
	localparam int CNT_W = $clog2(QUOT_W + 1);
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [QUOT_W-1:0] RATE_NUM_Q4 = 20'd960000;
	localparam logic [RATE_W-1:0] DEFAULT_Q4 = 12'd1200;

	localparam logic [STEP_W-1:0] RISE_STEP_RST = 18'd100;
	localparam logic [LIMIT_W-1:0] MIN_RATE_RST = 8'd40;
	localparam logic [LIMIT_W-1:0] MAX_RATE_RST = 8'd200;

	localparam logic [1:0] REG_RISE_STEP = 2'd0;
	localparam logic [1:0] REG_MIN_RATE = 2'd1;
	localparam logic [1:0] REG_MAX_RATE = 2'd2;

	localparam logic [1:0] SRC_DEFAULT = 2'd0;
	localparam logic [1:0] SRC_NONE = 2'd1;
	localparam logic [1:0] SRC_MEASURED = 2'd2;
	localparam logic [1:0] SRC_CLAMPED = 2'd3;

	typedef struct packed {
		logic [RAW_W-1:0] raw_sample;
		logic [TICK_W-1:0] tick_now;
	} sample_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_q4;
		logic beat_seen;
		logic [1:0] rate_source;
	} rate_t;

	typedef struct packed {
		logic [STEP_W-1:0] rise_step;
		logic [LIMIT_W-1:0] min_rate;
		logic [LIMIT_W-1:0] max_rate;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic [QUOT_W-1:0] quot;
		logic rem_nz;
	} div_res_t;

endpackage

// ----- sv/pulse_interval_rate_meter.sv -----
// pulse interval rate meter: one rate word out for every sample word in
// sample channel: valid/ready, word carries raw_sample and tick_now (ms)
// rate channel: valid/ready, word carries rate_q4 (1/16 bpm), beat_seen,
// rate_source; exactly one rate word per sample word, in order
// apb port: rise_step at 0x0, min_rate at 0x4, max_rate at 0x8
// a sample with no beat, or a first beat / zero interval, has its rate
// word registered in res_q and then moved to the output register; the
// next sample is taken only once the word has moved there
// a measured beat runs a bit-serial restoring divider, one quotient bit
// per cycle over 20 bits; the quotient after the limit test goes to res_q
// and then to the output register, and only then is a new sample taken
// the output register holds a finished word while the receiver stalls;
// the next sample is still taken and worked, and waits for the register
// reset clears the previous sample and the stored beat tick to zero and
// loads rise_step 100, min_rate 40, max_rate 200; no clearing pass
module pulse_interval_rate_meter #(
	parameter int SAMPLE_BITS = pirm_pkg::SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input pirm_pkg::sample_t sample,
	output logic rate_valid,
	input logic rate_ready,
	output pirm_pkg::rate_t rate,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pirm_pkg::ADDR_W-1:0] paddr,
	input logic [pirm_pkg::DATA_W-1:0] pwdata,
	output logic [pirm_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int SUM_W =
		((SAMPLE_BITS > pirm_pkg::STEP_W) ? SAMPLE_BITS : pirm_pkg::STEP_W) + 1;
	localparam int QW = pirm_pkg::QUOT_W;
	localparam int RW = pirm_pkg::RATE_W;

	pirm_pkg::cfg_t cfg;
	pirm_pkg::div_res_t div_res;

	logic [SAMPLE_BITS-1:0] prev_q;
	logic [pirm_pkg::TICK_W-1:0] last_tick_q;
	logic busy_q;
	logic div_run_q;
	pirm_pkg::rate_t res_q;
	pirm_pkg::rate_t out_q;
	logic out_valid_q;

	logic accept;
	logic [SAMPLE_BITS-1:0] smp;
	logic beat;
	logic [pirm_pkg::TICK_W-1:0] diff;
	logic need_div;
	logic xfer;
	logic [RW-1:0] hi;
	logic [RW-1:0] lo;
	pirm_pkg::rate_t direct;
	pirm_pkg::rate_t clamped;

	pirm_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign sample_ready = !busy_q;
	assign accept = sample_valid & sample_ready;
	assign smp = sample.raw_sample[SAMPLE_BITS-1:0];
	assign beat = SUM_W'(smp) > (SUM_W'(prev_q) + SUM_W'(cfg.rise_step));
	assign diff = sample.tick_now - last_tick_q;
	assign need_div = beat && (last_tick_q != '0) && (diff != '0);

	pirm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept & need_div),
		.divisor(diff),
		.res(div_res)
	);

	always_comb begin
		if (!beat) begin
			direct.rate_q4 = pirm_pkg::DEFAULT_Q4;
			direct.beat_seen = 1'b0;
			direct.rate_source = pirm_pkg::SRC_DEFAULT;
		end else begin
			direct.rate_q4 = '0;
			direct.beat_seen = 1'b1;
			direct.rate_source = pirm_pkg::SRC_NONE;
		end
	end

	// ceiling test first, on the exact quotient
	always_comb begin
		hi = {cfg.max_rate, 4'b0000};
		lo = {cfg.min_rate, 4'b0000};
		clamped.beat_seen = 1'b1;
		priority if ((div_res.quot > QW'(hi)) ||
				((div_res.quot == QW'(hi)) && div_res.rem_nz)) begin
			clamped.rate_q4 = hi;
			clamped.rate_source = pirm_pkg::SRC_CLAMPED;
		end else if (div_res.quot < QW'(lo)) begin
			clamped.rate_q4 = lo;
			clamped.rate_source = pirm_pkg::SRC_CLAMPED;
		end else begin
			clamped.rate_q4 = div_res.quot[RW-1:0];
			clamped.rate_source = pirm_pkg::SRC_MEASURED;
		end
	end

	assign xfer = busy_q & !div_run_q & (!out_valid_q | rate_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			last_tick_q <= '0;
			busy_q <= 1'b0;
			div_run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_q <= smp;
				if (beat) begin
					last_tick_q <= sample.tick_now;
				end
				busy_q <= 1'b1;
				div_run_q <= need_div;
			end else if (div_res.done) begin
				div_run_q <= 1'b0;
			end else if (xfer) begin
				busy_q <= 1'b0;
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (rate_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= direct;
		end else if (div_res.done) begin
			res_q <= clamped;
		end
		if (xfer) begin
			out_q <= res_q;
		end
	end

	assign rate_valid = out_valid_q;
	assign rate = out_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> div_run_q)
		else $error("divider finished with no division pending");

	a_src_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.rate_source == pirm_pkg::SRC_DEFAULT) == !out_q.beat_seen))
		else $error("rate source disagrees with beat flag");

	a_meas_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.rate_source == pirm_pkg::SRC_MEASURED)) |->
		((out_q.rate_q4 <= {cfg.max_rate, 4'b0000}) &&
		(out_q.rate_q4 >= {cfg.min_rate, 4'b0000})))
		else $error("measured rate outside the limits");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && !$past(div_run_q))
		else $error("rate word with no finished sample behind it");

	a_busy_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $rose(out_valid_q) || ($past(rate_ready) && out_valid_q))
		else $error("sample dropped without a rate word");

endmodule

// ----- sv/pirm_cfg.sv -----
module pirm_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pirm_pkg::ADDR_W-1:0] paddr,
	input logic [pirm_pkg::DATA_W-1:0] pwdata,
	output logic [pirm_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output pirm_pkg::cfg_t cfg
);

	logic [pirm_pkg::STEP_W-1:0] rise_step_q;
	logic [pirm_pkg::LIMIT_W-1:0] min_rate_q;
	logic [pirm_pkg::LIMIT_W-1:0] max_rate_q;
	logic [1:0] idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = paddr[3:2];
	assign wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_step_q <= pirm_pkg::RISE_STEP_RST;
			min_rate_q <= pirm_pkg::MIN_RATE_RST;
			max_rate_q <= pirm_pkg::MAX_RATE_RST;
		end else if (wr) begin
			unique case (idx)
				pirm_pkg::REG_RISE_STEP: rise_step_q <= pwdata[pirm_pkg::STEP_W-1:0];
				pirm_pkg::REG_MIN_RATE: min_rate_q <= pwdata[pirm_pkg::LIMIT_W-1:0];
				pirm_pkg::REG_MAX_RATE: max_rate_q <= pwdata[pirm_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pirm_pkg::REG_RISE_STEP:
				prdata = pirm_pkg::DATA_W'(rise_step_q);
			pirm_pkg::REG_MIN_RATE:
				prdata = pirm_pkg::DATA_W'(min_rate_q);
			pirm_pkg::REG_MAX_RATE:
				prdata = pirm_pkg::DATA_W'(max_rate_q);
			default:
				prdata = '0;
		endcase
	end

	assign cfg.rise_step = rise_step_q;
	assign cfg.min_rate = min_rate_q;
	assign cfg.max_rate = max_rate_q;

endmodule

// ----- sv/pirm_div.sv -----
module pirm_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [pirm_pkg::TICK_W-1:0] divisor,
	output pirm_pkg::div_res_t res
);

	localparam int QW = pirm_pkg::QUOT_W;
	localparam int DW = pirm_pkg::TICK_W;

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	logic [QW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] divisor_q;
	logic [pirm_pkg::CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [DW:0] rem_sh;
	logic [DW:0] sub;
	logic fit;
	logic [DW-1:0] rem_d;

	always_comb begin
		rem_sh = {rem_q, dvd_q[QW-1]};
		sub = rem_sh - {1'b0, divisor_q};
		fit = rem_sh >= {1'b0, divisor_q};
		rem_d = fit ? sub[DW-1:0] : rem_sh[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= pirm_pkg::CNT_W'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pirm_pkg::CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= pirm_pkg::RATE_NUM_Q4;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[QW-2:0], fit};
			rem_q <= rem_d;
		end
	end

	assign res.done = done_q;
	assign res.quot = dvd_q;
	assign res.rem_nz = |rem_q;

endmodule

// ----- dv/tb_pulse_interval_rate_meter.sv -----
module tb_pulse_interval_rate_meter;

	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 30;
	localparam logic [pirm_pkg::SAMPLE_BITS_DEF-1:0] LEVEL_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	pirm_pkg::sample_t sample = '0;
	logic rate_valid;
	logic rate_ready = 1'b0;
	pirm_pkg::rate_t rate;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pirm_pkg::ADDR_W-1:0] paddr = '0;
	logic [pirm_pkg::DATA_W-1:0] pwdata = '0;
	logic [pirm_pkg::DATA_W-1:0] prdata;
	logic pready;

	pulse_interval_rate_meter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.rate_valid(rate_valid),
		.rate_ready(rate_ready),
		.rate(rate),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block's settings and beat state
	logic [pirm_pkg::STEP_W-1:0] cfg_step = pirm_pkg::RISE_STEP_RST;
	logic [pirm_pkg::LIMIT_W-1:0] cfg_min = pirm_pkg::MIN_RATE_RST;
	logic [pirm_pkg::LIMIT_W-1:0] cfg_max = pirm_pkg::MAX_RATE_RST;
	logic [pirm_pkg::SAMPLE_BITS_DEF-1:0] prev_level = '0;
	logic [pirm_pkg::TICK_W-1:0] beat_tick = '0;
	logic [pirm_pkg::TICK_W-1:0] clock_ms = '0;

	pirm_pkg::rate_t expected_rates[$];
	int err_count = 0;
	int words_sent = 0;
	int n_default = 0;
	int n_no_interval = 0;
	int n_measured = 0;
	int n_clamped = 0;
	int cycle_count = 0;

	// receiver hold-off request, handed over by toggling hold_kick
	int hold_len = 0;
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic [15:0] stall_pat = 16'h00ff;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	function automatic pirm_pkg::rate_t predict_rate(input pirm_pkg::sample_t w);
		logic [pirm_pkg::SAMPLE_BITS_DEF-1:0] lvl;
		logic [pirm_pkg::RAW_W:0] bar;
		logic [pirm_pkg::TICK_W-1:0] gap_ms;
		logic [31:0] quot;
		logic [31:0] rem;
		logic [31:0] ceil_q4;
		logic [31:0] floor_q4;
		pirm_pkg::rate_t res;
		lvl = w.raw_sample[pirm_pkg::SAMPLE_BITS_DEF-1:0];
		bar = (pirm_pkg::RAW_W+1)'(prev_level) + (pirm_pkg::RAW_W+1)'(cfg_step);
		res.rate_q4 = pirm_pkg::DEFAULT_Q4;
		res.beat_seen = 1'b0;
		res.rate_source = pirm_pkg::SRC_DEFAULT;
		if ((pirm_pkg::RAW_W+1)'(lvl) > bar) begin
			res.beat_seen = 1'b1;
			gap_ms = w.tick_now - beat_tick;
			if (beat_tick == '0 || gap_ms == '0) begin
				res.rate_q4 = '0;
				res.rate_source = pirm_pkg::SRC_NONE;
			end else begin
				quot = 32'(pirm_pkg::RATE_NUM_Q4) / gap_ms;
				rem = 32'(pirm_pkg::RATE_NUM_Q4) % gap_ms;
				ceil_q4 = 32'({cfg_max, 4'b0});
				floor_q4 = 32'({cfg_min, 4'b0});
				// ceiling uses the exact quotient, so a remainder tips it over
				if (quot > ceil_q4 || (quot == ceil_q4 && rem != 0)) begin
					res.rate_q4 = ceil_q4[pirm_pkg::RATE_W-1:0];
					res.rate_source = pirm_pkg::SRC_CLAMPED;
				end else if (quot < floor_q4) begin
					res.rate_q4 = floor_q4[pirm_pkg::RATE_W-1:0];
					res.rate_source = pirm_pkg::SRC_CLAMPED;
				end else begin
					res.rate_q4 = quot[pirm_pkg::RATE_W-1:0];
					res.rate_source = pirm_pkg::SRC_MEASURED;
				end
			end
			beat_tick = w.tick_now;
		end
		prev_level = lvl;
		return res;
	endfunction

	// shaped words follow a pulse train; the rest is noise
	function automatic pirm_pkg::sample_t make_sample(input logic shaped);
		logic [pirm_pkg::SAMPLE_BITS_DEF:0] bar;
		logic [pirm_pkg::SAMPLE_BITS_DEF-1:0] top;
		logic [pirm_pkg::SAMPLE_BITS_DEF-1:0] lvl;
		int unsigned sum;
		pirm_pkg::sample_t w;
		if (shaped) begin
			bar = (pirm_pkg::SAMPLE_BITS_DEF+1)'(prev_level) +
				(pirm_pkg::SAMPLE_BITS_DEF+1)'(cfg_step);
			top = (bar > LEVEL_MAX) ? LEVEL_MAX : bar[pirm_pkg::SAMPLE_BITS_DEF-1:0];
			if (bar < LEVEL_MAX && $urandom_range(0, 7) == 0) begin
				sum = bar + $urandom_range(1, 4000);
				lvl = (sum > LEVEL_MAX) ? LEVEL_MAX : pirm_pkg::SAMPLE_BITS_DEF'(sum);
				if ($urandom_range(0, 31) != 0)
					clock_ms = clock_ms + $urandom_range(20, 500);
			end else begin
				lvl = ($urandom_range(0, 3) == 0) ? top :
					pirm_pkg::SAMPLE_BITS_DEF'($urandom_range(0, top));
				clock_ms = clock_ms + $urandom_range(10, 80);
			end
			w.raw_sample = {(pirm_pkg::RAW_W-pirm_pkg::SAMPLE_BITS_DEF)'($urandom), lvl};
			w.tick_now = clock_ms;
		end else begin
			w.raw_sample = pirm_pkg::RAW_W'($urandom);
			case ($urandom_range(0, 3))
				0: w.tick_now = $urandom;
				1: w.tick_now = beat_tick;
				default: w.tick_now = clock_ms + $urandom_range(0, 2000);
			endcase
			clock_ms = w.tick_now;
		end
		return w;
	endfunction

	task automatic send_sample(input pirm_pkg::sample_t w);
		sample <= w;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		expected_rates.push_back(predict_rate(w));
		words_sent++;
	endtask

	task automatic send_at(input logic [pirm_pkg::RAW_W-1:0] raw,
		input logic [pirm_pkg::TICK_W-1:0] tick);
		pirm_pkg::sample_t w;
		w.raw_sample = raw;
		w.tick_now = tick;
		clock_ms = tick;
		send_sample(w);
	endtask

	// low word then full-scale word dt ms after the stored beat
	task automatic beat_after(input logic [pirm_pkg::TICK_W-1:0] dt);
		send_at(24'h000000, beat_tick + 1);
		send_at(24'hC3FFFF, beat_tick + dt);
	endtask

	task automatic idle_sender(input int n);
		sample_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drain();
		sample_valid <= 1'b0;
		while (expected_rates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx, input logic [pirm_pkg::DATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [pirm_pkg::DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pirm_pkg::REG_RISE_STEP: cfg_step = val[pirm_pkg::STEP_W-1:0];
			pirm_pkg::REG_MIN_RATE: cfg_min = val[pirm_pkg::LIMIT_W-1:0];
			pirm_pkg::REG_MAX_RATE: cfg_max = val[pirm_pkg::LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		read_reg(idx, val);
	endtask

	task automatic set_limits(input logic [pirm_pkg::STEP_W-1:0] step,
		input logic [pirm_pkg::LIMIT_W-1:0] lo, input logic [pirm_pkg::LIMIT_W-1:0] hi);
		wait_drain();
		write_reg(pirm_pkg::REG_RISE_STEP, pirm_pkg::DATA_W'(step));
		write_reg(pirm_pkg::REG_MIN_RATE, pirm_pkg::DATA_W'(lo));
		write_reg(pirm_pkg::REG_MAX_RATE, pirm_pkg::DATA_W'(hi));
	endtask

	task automatic run_traffic(input int n);
		int left;
		int burst;
		int gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 16);
			if (burst > left)
				burst = left;
			repeat (burst) send_sample(make_sample($urandom_range(0, 3) != 0));
			left -= burst;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0)
				idle_sender(gap);
		end
	endtask

	task automatic test_reset_values();
		read_reg(pirm_pkg::REG_RISE_STEP, pirm_pkg::DATA_W'(pirm_pkg::RISE_STEP_RST));
		read_reg(pirm_pkg::REG_MIN_RATE, pirm_pkg::DATA_W'(pirm_pkg::MIN_RATE_RST));
		read_reg(pirm_pkg::REG_MAX_RATE, pirm_pkg::DATA_W'(pirm_pkg::MAX_RATE_RST));
	endtask

	task automatic test_directed_cases();
		send_at(24'h000000, 32'd0);
		// first beat lands on tick zero, so the next beat is a first beat too
		send_at(24'hFFFFFF, 32'd0);
		send_at(24'hFC0000, 32'd7);
		send_at(24'h000064, 32'd8);
		send_at(24'h000000, 32'd9);
		send_at(24'h000065, 32'd1000);
		send_at(24'h000000, 32'd1010);
		send_at(24'h001388, 32'd1000);
		beat_after(32'd750);
		beat_after(32'd300);
		beat_after(32'd100);
		beat_after(32'd1500);
		beat_after(32'd30000);
		send_at(24'h000000, 32'hFFFF_FE00);
		send_at(24'h3FFFFF, 32'hFFFF_FF00);
		// interval across the tick wrap
		beat_after(32'h200);
	endtask

	task automatic test_register_extremes();
		set_limits(18'h3FFFF, 8'd0, 8'd255);
		send_at(24'h000000, beat_tick + 1);
		send_at(24'h03FFFF, beat_tick + 2);
		set_limits(18'd0, 8'd0, 8'd255);
		send_at(24'hABFFFF, beat_tick + 3);
		beat_after(32'd960001);
		set_limits(18'd0, 8'd0, 8'd1);
		beat_after(32'd60000);
		beat_after(32'd59999);
		set_limits(18'd0, 8'd0, 8'd0);
		beat_after(32'd1000);
		set_limits(18'd0, 8'd200, 8'd50);
		beat_after(32'd1000);
		beat_after(32'd5000);
	endtask

	task automatic test_shaped_traffic();
		set_limits(pirm_pkg::RISE_STEP_RST, pirm_pkg::MIN_RATE_RST, pirm_pkg::MAX_RATE_RST);
		run_traffic(160);
		set_limits(18'd0, 8'd0, 8'd255);
		run_traffic(160);
		set_limits(18'h3FFFF, 8'd255, 8'd0);
		run_traffic(160);
		set_limits(18'd1500, 8'd60, 8'd180);
		clock_ms = 32'hFFFF_8000;
		run_traffic(160);
		set_limits(18'd50, 8'd200, 8'd50);
		run_traffic(160);
		set_limits(18'd3000, 8'd0, 8'd0);
		run_traffic(160);
	endtask

	task automatic test_backpressure();
		set_limits(18'd200, 8'd45, 8'd190);
		hold_len <= 400;
		hold_kick <= ~hold_kick;
		repeat (60) send_sample(make_sample(1'b1));
		wait_drain();
	endtask

	task automatic test_drain_pause();
		run_traffic(100);
		wait_drain();
		run_traffic(100);
		wait_drain();
	endtask

	// receiver: long hold-offs on request, otherwise a stall mode that changes now and then
	always @(posedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= hold_len;
			rate_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rate_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(20, 120);
				stall_pat <= 16'($urandom) | 16'h0001;
			end else begin
				mode_left <= mode_left - 1;
				stall_pat <= {stall_pat[14:0], stall_pat[15]};
			end
			case (stall_mode)
				0: rate_ready <= 1'b1;
				1: rate_ready <= stall_pat[0];
				default: rate_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		pirm_pkg::rate_t want;
		if (arst_n && rate_valid && rate_ready) begin
			if (expected_rates.size() == 0) begin
				report_mismatch("rate word with none outstanding", 32'(rate), 32'd0);
			end else begin
				want = expected_rates.pop_front();
				if (rate.rate_q4 !== want.rate_q4)
					report_mismatch("rate_q4", 32'(rate.rate_q4), 32'(want.rate_q4));
				if (rate.beat_seen !== want.beat_seen)
					report_mismatch("beat_seen", 32'(rate.beat_seen), 32'(want.beat_seen));
				if (rate.rate_source !== want.rate_source)
					report_mismatch("rate_source", 32'(rate.rate_source),
						32'(want.rate_source));
				case (want.rate_source)
					pirm_pkg::SRC_DEFAULT: n_default++;
					pirm_pkg::SRC_NONE: n_no_interval++;
					pirm_pkg::SRC_MEASURED: n_measured++;
					default: n_clamped++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_cases();
		test_register_extremes();
		test_shaped_traffic();
		test_backpressure();
		test_drain_pause();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_rates.size() != 0)
			report_mismatch("rate words never delivered", 32'(expected_rates.size()), 32'd0);
		$display("covered %0d sample words over eleven register settings, inverted limits too,",
			words_sent);
		$display("and a long receiver hold-off; rate words: %0d default, %0d first beat or %s",
			n_default, n_no_interval, "zero interval");
		$display("  %0d measured, %0d clamped", n_measured, n_clamped);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
